// File: rtl/rmq_pkg.sv
// Shared widths, types, pivot codes and helpers for the matrix-to-quaternion pipeline.
package rmq_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ONE       = 1 << FRAC_BITS;

    localparam int IN_W      = 18;
    localparam int OUT_W     = 18;
    localparam int SUM_W     = IN_W + 2;
    localparam int RAD_W     = SUM_W - 1;
    localparam int VAL_W     = IN_W + 1;
    localparam int MAG_W     = VAL_W;

    localparam int SQ_IN_W   = 38;
    localparam int SQ_OUT_W  = SQ_IN_W / 2;
    localparam int SQ_REM_W  = SQ_OUT_W + 3;

    localparam int DEN_W     = VAL_W;
    localparam int QUO_BITS  = IN_W;
    localparam int NUM_W     = MAG_W + FRAC_BITS;

    localparam int SQR_W     = 2 * (MAG_W - 1);

    localparam logic [1:0] PIV_W = 2'd0;
    localparam logic [1:0] PIV_X = 2'd1;
    localparam logic [1:0] PIV_Y = 2'd2;
    localparam logic [1:0] PIV_Z = 2'd3;

    localparam logic signed [VAL_W-1:0] V_MAX = VAL_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [VAL_W-1:0] V_MIN = -VAL_W'(1 << (OUT_W - 1));

    typedef logic signed [VAL_W-1:0] t_val;
    typedef t_val [3:0] t_vec;

    typedef struct packed {
        t_vec       v;
        logic [1:0] piv;
    } t_side;

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        r = v;
        if (v > V_MAX) begin
            r = V_MAX;
        end else if (v < V_MIN) begin
            r = V_MIN;
        end
        return r[OUT_W-1:0];
    endfunction

endpackage

// File: rtl/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module rmq_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [rmq_pkg::SQ_IN_W-1:0]  i_rad,
    input  rmq_pkg::t_side               i_side,
    output logic                         o_vld,
    output logic [rmq_pkg::SQ_OUT_W-1:0] o_root,
    output rmq_pkg::t_side               o_side
);

    localparam int N = rmq_pkg::SQ_OUT_W;

    logic                          r_vld  [N+1];
    logic [rmq_pkg::SQ_IN_W-1:0]   r_x    [N+1];
    logic [rmq_pkg::SQ_REM_W-1:0]  r_rem  [N+1];
    logic [rmq_pkg::SQ_OUT_W-1:0]  r_root [N+1];
    rmq_pkg::t_side                r_side [N+1];

    logic [rmq_pkg::SQ_REM_W-1:0]  n_sh   [N];
    logic [rmq_pkg::SQ_REM_W-1:0]  n_try  [N];
    logic                          n_bit  [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stg
        always_comb begin
            n_sh[g]  = {r_rem[g][rmq_pkg::SQ_REM_W-3:0],
                        r_x[g][rmq_pkg::SQ_IN_W-1:rmq_pkg::SQ_IN_W-2]};
            n_try[g] = {1'b0, r_root[g], 2'b01};
            n_bit[g] = (n_sh[g] >= n_try[g]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g+1]    <= {r_x[g][rmq_pkg::SQ_IN_W-3:0], 2'b00};
                r_rem[g+1]  <= n_bit[g] ? (n_sh[g] - n_try[g]) : n_sh[g];
                r_root[g+1] <= {r_root[g][N-2:0], n_bit[g]};
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_vld  = r_vld[N];
    assign o_root = r_root[N];
    assign o_side = r_side[N];

endmodule

// File: rtl/rmq_div.sv
// Four-lane pipelined signed divider by a shared positive divisor, one quotient bit per stage.
module rmq_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  rmq_pkg::t_vec             i_num,
    input  logic [rmq_pkg::DEN_W-1:0] i_den,
    input  rmq_pkg::t_side            i_side,
    output logic                      o_vld,
    output rmq_pkg::t_vec             o_quo,
    output rmq_pkg::t_side            o_side
);

    localparam int N = rmq_pkg::QUO_BITS;
    localparam int D = rmq_pkg::DEN_W;

    logic                   r_vld  [N+1];
    logic [D-1:0]           r_den  [N+1];
    rmq_pkg::t_side         r_side [N+1];
    logic [D-1:0]           r_rem  [N+1][4];
    logic [N-1:0]           r_low  [N+1][4];
    logic [N-1:0]           r_q    [N+1][4];
    logic                   r_neg  [N+1][4];

    logic [rmq_pkg::MAG_W-1:0] n_mag [4];
    logic [rmq_pkg::NUM_W-1:0] n_num [4];
    logic [D:0]                n_sh  [N][4];
    logic [D+1:0]              n_dif [N][4];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            n_mag[l] = i_num[l][rmq_pkg::VAL_W-1] ? rmq_pkg::MAG_W'(-i_num[l])
                                                  : rmq_pkg::MAG_W'(i_num[l]);
            n_num[l] = {n_mag[l], {rmq_pkg::FRAC_BITS{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int l = 0; l < 4; l++) begin
                r_rem[0][l] <= D'(n_num[l][rmq_pkg::NUM_W-1:N]);
                r_low[0][l] <= n_num[l][N-1:0];
                r_q[0][l]   <= '0;
                r_neg[0][l] <= i_num[l][rmq_pkg::VAL_W-1];
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stg
        always_comb begin
            for (int l = 0; l < 4; l++) begin
                n_sh[g][l]  = {r_rem[g][l], r_low[g][l][N-1]};
                n_dif[g][l] = {1'b0, n_sh[g][l]} - {2'b00, r_den[g]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g+1]  <= r_den[g];
                r_side[g+1] <= r_side[g];
                for (int l = 0; l < 4; l++) begin
                    r_rem[g+1][l] <= n_dif[g][l][D+1] ? n_sh[g][l][D-1:0]
                                                      : n_dif[g][l][D-1:0];
                    r_low[g+1][l] <= {r_low[g][l][N-2:0], 1'b0};
                    r_q[g+1][l]   <= {r_q[g][l][N-2:0], ~n_dif[g][l][D+1]};
                    r_neg[g+1][l] <= r_neg[g][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            o_quo[l] = r_neg[N][l] ? -rmq_pkg::VAL_W'(r_q[N][l])
                                   : rmq_pkg::VAL_W'(r_q[N][l]);
        end
    end

    assign o_vld  = r_vld[N];
    assign o_side = r_side[N];

endmodule

// File: rtl/rmq_norm.sv
// Squared norm of the four unnormalized components: squares, then a two-level adder tree.
module rmq_norm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  rmq_pkg::t_side              i_side,
    output logic                        o_vld,
    output logic [rmq_pkg::SQ_IN_W-1:0] o_n2,
    output rmq_pkg::t_side              o_side
);

    localparam int H = rmq_pkg::MAG_W - 1;

    logic [H-1:0]                r_mag [4];
    logic                        r_vld0;
    rmq_pkg::t_side              r_side0;
    logic [rmq_pkg::SQR_W-1:0]   r_sq  [4];
    logic                        r_vld1;
    rmq_pkg::t_side              r_side1;
    logic [rmq_pkg::SQR_W:0]     r_pair [2];
    logic                        r_vld2;
    rmq_pkg::t_side              r_side2;
    logic [rmq_pkg::SQ_IN_W-1:0] r_sum;
    logic                        r_vld3;
    rmq_pkg::t_side              r_side3;

    logic [rmq_pkg::MAG_W-1:0]   n_abs [4];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            n_abs[l] = i_side.v[l][rmq_pkg::VAL_W-1] ? rmq_pkg::MAG_W'(-i_side.v[l])
                                                     : rmq_pkg::MAG_W'(i_side.v[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld0 <= i_vld;
            r_vld1 <= r_vld0;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 4; l++) begin
                r_mag[l] <= n_abs[l][H-1:0];
                r_sq[l]  <= r_mag[l] * r_mag[l];
            end
            r_pair[0] <= {1'b0, r_sq[0]} + {1'b0, r_sq[1]};
            r_pair[1] <= {1'b0, r_sq[2]} + {1'b0, r_sq[3]};
            r_sum     <= rmq_pkg::SQ_IN_W'(r_pair[0]) + rmq_pkg::SQ_IN_W'(r_pair[1]);
            r_side0   <= i_side;
            r_side1   <= r_side0;
            r_side2   <= r_side1;
            r_side3   <= r_side2;
        end
    end

    assign o_vld  = r_vld3;
    assign o_n2   = r_sum;
    assign o_side = r_side3;

endmodule

// File: rtl/rotation_matrix_to_quaternion_top.sv
// Top level: rotation matrix to unit quaternion pipeline (Shepperd's method).
//
// Takes one 3x3 matrix in signed Q1.16 per transfer and returns the unit quaternion
// (w, x, y, z) in Q1.16 and the index of the chosen pivot. A new matrix is taken every
// cycle whenever the output side is ready. Each item passes through the pivot sums and
// selection register, a square root (one root bit per stage), a four-lane divider (one
// quotient bit per stage), the squared norm, a second square root and four-lane divider
// and the output register. Any output stall freezes the whole pipeline; no item is
// dropped or repeated.
module rotation_matrix_to_quaternion_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [rmq_pkg::IN_W-1:0]  i_m00,
    input  logic signed [rmq_pkg::IN_W-1:0]  i_m01,
    input  logic signed [rmq_pkg::IN_W-1:0]  i_m02,
    input  logic signed [rmq_pkg::IN_W-1:0]  i_m10,
    input  logic signed [rmq_pkg::IN_W-1:0]  i_m11,
    input  logic signed [rmq_pkg::IN_W-1:0]  i_m12,
    input  logic signed [rmq_pkg::IN_W-1:0]  i_m20,
    input  logic signed [rmq_pkg::IN_W-1:0]  i_m21,
    input  logic signed [rmq_pkg::IN_W-1:0]  i_m22,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [rmq_pkg::OUT_W-1:0] o_qw,
    output logic signed [rmq_pkg::OUT_W-1:0] o_qx,
    output logic signed [rmq_pkg::OUT_W-1:0] o_qy,
    output logic signed [rmq_pkg::OUT_W-1:0] o_qz,
    output logic [1:0]                       o_pivot
);

    localparam int SW = rmq_pkg::SUM_W;
    localparam int VW = rmq_pkg::VAL_W;

    logic w_en;

    logic signed [SW-1:0] w_a, w_b, w_c2, w_one;
    logic signed [SW-1:0] w_s [4];
    logic [1:0]           w_piv;
    logic signed [SW-1:0] w_ssel;
    rmq_pkg::t_side       w_fside;
    logic signed [VW-1:0] w_d21m, w_d02m, w_d10m, w_d10p, w_d02p, w_d21p;

    logic                 r_f_vld;
    logic [rmq_pkg::RAD_W-1:0] r_f_rad;
    rmq_pkg::t_side       r_f_side;

    logic                           w_s1_vld;
    logic [rmq_pkg::SQ_OUT_W-1:0]   w_root1;
    rmq_pkg::t_side                 w_s1_side;
    rmq_pkg::t_side                 w_d1_in_side;

    logic                 w_d1_vld;
    rmq_pkg::t_vec        w_quo1;
    rmq_pkg::t_side       w_d1_side;
    rmq_pkg::t_side       w_c_side;

    logic                           w_n_vld;
    logic [rmq_pkg::SQ_IN_W-1:0]    w_n2;
    rmq_pkg::t_side                 w_n_side;

    logic                           w_s2_vld;
    logic [rmq_pkg::SQ_OUT_W-1:0]   w_root2;
    rmq_pkg::t_side                 w_s2_side;
    logic [rmq_pkg::DEN_W-1:0]      w_den2;

    logic                 w_d2_vld;
    rmq_pkg::t_vec        w_quo2;
    rmq_pkg::t_side       w_d2_side;

    logic                       r_out_vld;
    logic [rmq_pkg::OUT_W-1:0]  r_qw, r_qx, r_qy, r_qz;
    logic [1:0]                 r_piv;

    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en;

    // pivot sums, pivot selection and off-diagonal terms
    always_comb begin
        w_one = SW'(rmq_pkg::ONE);
        w_a   = SW'(i_m00);
        w_b   = SW'(i_m11);
        w_c2  = SW'(i_m22);
        w_s[0] = w_one + w_a + w_b + w_c2;
        w_s[1] = w_one + w_a - w_b - w_c2;
        w_s[2] = w_one - w_a + w_b - w_c2;
        w_s[3] = w_one - w_a - w_b + w_c2;
        w_piv  = rmq_pkg::PIV_W;
        w_ssel = w_s[0];
        if (w_s[1] > w_ssel) begin
            w_piv  = rmq_pkg::PIV_X;
            w_ssel = w_s[1];
        end
        if (w_s[2] > w_ssel) begin
            w_piv  = rmq_pkg::PIV_Y;
            w_ssel = w_s[2];
        end
        if (w_s[3] > w_ssel) begin
            w_piv  = rmq_pkg::PIV_Z;
            w_ssel = w_s[3];
        end

        w_d21m = VW'(i_m21) - VW'(i_m12);
        w_d02m = VW'(i_m02) - VW'(i_m20);
        w_d10m = VW'(i_m10) - VW'(i_m01);
        w_d10p = VW'(i_m10) + VW'(i_m01);
        w_d02p = VW'(i_m02) + VW'(i_m20);
        w_d21p = VW'(i_m21) + VW'(i_m12);

        w_fside.piv = w_piv;
        w_fside.v   = '0;
        case (w_piv)
            rmq_pkg::PIV_W: begin
                w_fside.v[1] = w_d21m;
                w_fside.v[2] = w_d02m;
                w_fside.v[3] = w_d10m;
            end
            rmq_pkg::PIV_X: begin
                w_fside.v[0] = w_d21m;
                w_fside.v[2] = w_d10p;
                w_fside.v[3] = w_d02p;
            end
            rmq_pkg::PIV_Y: begin
                w_fside.v[0] = w_d02m;
                w_fside.v[1] = w_d10p;
                w_fside.v[3] = w_d21p;
            end
            default: begin
                w_fside.v[0] = w_d10m;
                w_fside.v[1] = w_d02p;
                w_fside.v[2] = w_d21p;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_en) begin
            r_f_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_rad  <= w_ssel[rmq_pkg::RAD_W-1:0];
            r_f_side <= w_fside;
        end
    end

    rmq_sqrt u_sqrt_piv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_f_vld),
        .i_rad   (rmq_pkg::SQ_IN_W'(r_f_rad) << (rmq_pkg::FRAC_BITS - 2)),
        .i_side  (r_f_side),
        .o_vld   (w_s1_vld),
        .o_root  (w_root1),
        .o_side  (w_s1_side)
    );

    always_comb begin
        w_d1_in_side      = w_s1_side;
        w_d1_in_side.v    = '0;
        w_d1_in_side.v[0] = VW'(w_root1);
    end

    rmq_div u_div_piv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_s1_vld),
        .i_num   (w_s1_side.v),
        .i_den   (rmq_pkg::DEN_W'({w_root1, 2'b00})),
        .i_side  (w_d1_in_side),
        .o_vld   (w_d1_vld),
        .o_quo   (w_quo1),
        .o_side  (w_d1_side)
    );

    always_comb begin
        w_c_side.piv = w_d1_side.piv;
        for (int l = 0; l < 4; l++) begin
            w_c_side.v[l] = (w_d1_side.piv == 2'(l)) ? w_d1_side.v[0] : w_quo1[l];
        end
    end

    rmq_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_d1_vld),
        .i_side  (w_c_side),
        .o_vld   (w_n_vld),
        .o_n2    (w_n2),
        .o_side  (w_n_side)
    );

    rmq_sqrt u_sqrt_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_n_vld),
        .i_rad   (w_n2),
        .i_side  (w_n_side),
        .o_vld   (w_s2_vld),
        .o_root  (w_root2),
        .o_side  (w_s2_side)
    );

    assign w_den2 = (w_root2 == '0) ? rmq_pkg::DEN_W'(1) : rmq_pkg::DEN_W'(w_root2);

    rmq_div u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_s2_vld),
        .i_num   (w_s2_side.v),
        .i_den   (w_den2),
        .i_side  (w_s2_side),
        .o_vld   (w_d2_vld),
        .o_quo   (w_quo2),
        .o_side  (w_d2_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qw  <= rmq_pkg::sat_out(w_quo2[0]);
            r_qx  <= rmq_pkg::sat_out(w_quo2[1]);
            r_qy  <= rmq_pkg::sat_out(w_quo2[2]);
            r_qz  <= rmq_pkg::sat_out(w_quo2[3]);
            r_piv <= w_d2_side.piv;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_qw        = r_qw;
    assign o_qx        = r_qx;
    assign o_qy        = r_qy;
    assign o_qz        = r_qz;
    assign o_pivot     = r_piv;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_pivot_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_vld |-> w_root1 >= rmq_pkg::SQ_OUT_W'(1 << (rmq_pkg::FRAC_BITS - 1)))
        else $error("pivot component below one half");

    a_pivot_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pivot == rmq_pkg::PIV_W && !o_qw[rmq_pkg::OUT_W-1]) ||
                        (o_pivot == rmq_pkg::PIV_X && !o_qx[rmq_pkg::OUT_W-1]) ||
                        (o_pivot == rmq_pkg::PIV_Y && !o_qy[rmq_pkg::OUT_W-1]) ||
                        (o_pivot == rmq_pkg::PIV_Z && !o_qz[rmq_pkg::OUT_W-1]))
        else $error("pivot component negative");

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_qw <= rmq_pkg::OUT_W'(rmq_pkg::ONE) &&
                        o_qw >= -rmq_pkg::OUT_W'(rmq_pkg::ONE) &&
                        o_qx <= rmq_pkg::OUT_W'(rmq_pkg::ONE) &&
                        o_qx >= -rmq_pkg::OUT_W'(rmq_pkg::ONE) &&
                        o_qy <= rmq_pkg::OUT_W'(rmq_pkg::ONE) &&
                        o_qy >= -rmq_pkg::OUT_W'(rmq_pkg::ONE) &&
                        o_qz <= rmq_pkg::OUT_W'(rmq_pkg::ONE) &&
                        o_qz >= -rmq_pkg::OUT_W'(rmq_pkg::ONE))
        else $error("component exceeds unit magnitude");
`endif

endmodule
